@@ rtl/core/lpc_pkg.sv @@
// Shared constants, types and lookup functions for the label pseudo-color pipeline.
package lpc_pkg;

    localparam int LabelWidth   = 31;
    localparam int ColorWidth   = 8;
    localparam int NumLevels    = 9;
    localparam int NumPatterns  = 27;
    localparam int NumModes     = 6;
    localparam int DiagBase     = 9;
    localparam int PairBase     = 15;
    localparam int FirstLvlPat  = 8;
    localparam int LabelPeriod  = 729;

    // 2^10 and 2^20 modulo 729
    localparam int Res10        = 295;
    localparam int Res20        = 274;
    // ceil(2^30 / 729), exact quotient for sums below 2^20
    localparam int RecipK       = 1472897;
    localparam int RecipShift   = 30;
    // floor(r * 171 / 1024) == r / 6 for r below 216
    localparam int Div6K        = 171;

    typedef logic [9:0] lpc_res_t;
    typedef logic [3:0] lpc_lvl_t;
    typedef logic [5:0] lpc_slot_t;
    typedef logic [4:0] lpc_pat_t;

    typedef struct packed {
        lpc_slot_t slot0;
        lpc_slot_t slot1;
        lpc_slot_t slot2;
        lpc_pat_t  pat;
    } lpc_slots_t;

    // (m+1)^3
    function automatic lpc_res_t lpc_cube(input lpc_lvl_t m);
        lpc_res_t c;
        case (m)
            4'd0:    c = 10'd1;
            4'd1:    c = 10'd8;
            4'd2:    c = 10'd27;
            4'd3:    c = 10'd64;
            4'd4:    c = 10'd125;
            4'd5:    c = 10'd216;
            4'd6:    c = 10'd343;
            4'd7:    c = 10'd512;
            default: c = 10'd729;
        endcase
        return c;
    endfunction

    function automatic logic [ColorWidth-1:0] lpc_level_value(input lpc_lvl_t lv);
        logic [ColorWidth-1:0] c;
        case (lv)
            4'd0:    c = 8'd0;
            4'd1:    c = 8'd255;
            4'd2:    c = 8'd127;
            4'd3:    c = 8'd63;
            4'd4:    c = 8'd191;
            4'd5:    c = 8'd31;
            4'd6:    c = 8'd95;
            4'd7:    c = 8'd159;
            default: c = 8'd223;
        endcase
        return c;
    endfunction

    // slot selects {red, green, blue}, two bits each
    function automatic logic [5:0] lpc_pattern(input lpc_pat_t p);
        logic [5:0] s;
        case (p)
            5'd0:    s = {2'd0, 2'd0, 2'd0};
            5'd1:    s = {2'd1, 2'd1, 2'd1};
            5'd2:    s = {2'd1, 2'd0, 2'd0};
            5'd3:    s = {2'd0, 2'd1, 2'd0};
            5'd4:    s = {2'd0, 2'd0, 2'd1};
            5'd5:    s = {2'd1, 2'd1, 2'd0};
            5'd6:    s = {2'd1, 2'd0, 2'd1};
            5'd7:    s = {2'd0, 2'd1, 2'd1};
            5'd8:    s = {2'd2, 2'd2, 2'd2};
            5'd9:    s = {2'd2, 2'd0, 2'd0};
            5'd10:   s = {2'd0, 2'd2, 2'd0};
            5'd11:   s = {2'd0, 2'd0, 2'd2};
            5'd12:   s = {2'd2, 2'd2, 2'd0};
            5'd13:   s = {2'd2, 2'd0, 2'd2};
            5'd14:   s = {2'd0, 2'd2, 2'd2};
            5'd15:   s = {2'd2, 2'd1, 2'd0};
            5'd16:   s = {2'd2, 2'd0, 2'd1};
            5'd17:   s = {2'd1, 2'd2, 2'd0};
            5'd18:   s = {2'd0, 2'd2, 2'd1};
            5'd19:   s = {2'd1, 2'd0, 2'd2};
            5'd20:   s = {2'd0, 2'd1, 2'd2};
            5'd21:   s = {2'd1, 2'd2, 2'd2};
            5'd22:   s = {2'd2, 2'd1, 2'd2};
            5'd23:   s = {2'd2, 2'd2, 2'd1};
            5'd24:   s = {2'd2, 2'd1, 2'd1};
            5'd25:   s = {2'd1, 2'd2, 2'd1};
            default: s = {2'd1, 2'd1, 2'd2};
        endcase
        return s;
    endfunction

endpackage

@@ rtl/core/lpc_mod_reduce.sv @@
// Three-stage reduction of the label modulo 729.
module lpc_mod_reduce (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [lpc_pkg::LabelWidth-1:0]    label,
    output logic                              out_valid,
    output lpc_pkg::lpc_res_t                 residue
);
    import lpc_pkg::*;

    logic [19:0] sum_next, sum_reg, sum2_reg;
    logic [40:0] prod;
    logic [10:0] quo_next, quo_reg;
    logic [19:0] rem_full;
    lpc_res_t    res_next, res_reg;
    logic        v1_reg, v2_reg, v3_reg;

    // fold the three label chunks by their weights mod 729
    assign sum_next = 20'(label[9:0])
                    + 20'(label[19:10]) * 20'(Res10)
                    + 20'(label[30:20]) * 20'(Res20);

    assign prod     = 41'(sum_reg) * 41'(RecipK);
    assign quo_next = prod[RecipShift+10:RecipShift];

    assign rem_full = sum2_reg - 20'(quo_reg) * 20'(LabelPeriod);
    assign res_next = rem_full[9:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg  <= sum_next;
            sum2_reg <= sum_reg;
            quo_reg  <= quo_next;
            res_reg  <= res_next;
        end
    end

    assign out_valid = v3_reg;
    assign residue   = res_reg;

endmodule

@@ rtl/core/lpc_level_split.sv @@
// Level search, mode split and triangular pair walk, two stages.
module lpc_level_split (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  lpc_pkg::lpc_res_t    residue,
    output logic                 out_valid,
    output lpc_pkg::lpc_slots_t  slots
);
    import lpc_pkg::*;

    lpc_lvl_t    m_next, m_reg;
    lpc_res_t    r_full;
    logic [7:0]  rm1_next, rm1_reg;
    logic [15:0] div_prod;
    lpc_slot_t   s_next, s_reg;
    logic        first_next, first_reg;
    lpc_res_t    v_reg;
    logic        va_reg, vb_reg;

    logic [7:0]  mode_full;
    logic [2:0]  mode;
    lpc_slot_t   s_work;
    lpc_lvl_t    i_work;
    logic [6:0]  row_start;
    logic [6:0]  t_work;
    lpc_slots_t  slots_next, slots_reg;

    // stage A: level count, offset within level, split by six
    always_comb
    begin
        m_next = '0;
        for (int k = 0; k < NumLevels - 1; k++)
        begin
            if (residue >= lpc_cube(lpc_lvl_t'(k)))
                m_next = m_next + 4'd1;
        end
        r_full     = residue - lpc_cube(m_next - 4'd1);
        first_next = (r_full == '0);
        rm1_next   = 8'(r_full - 10'd1);
        div_prod   = 16'(rm1_next) * 16'(Div6K);
        s_next     = div_prod[15:10];
    end

    // stage B: mode, upper-triangular walk, slot triple
    always_comb
    begin
        mode_full = rm1_reg - 8'(s_reg) * 8'(NumModes);
        mode      = mode_full[2:0];
        // row j of the triangle starts at j*m - j*(j-1)/2; all rows compared at once,
        // the last row start not above s wins
        i_work    = '0;
        t_work    = '0;
        row_start = '0;
        for (int j = 1; j < NumLevels; j++)
        begin
            row_start = 7'(j) * 7'(m_reg) - 7'(j * (j - 1) / 2);
            if (lpc_lvl_t'(j) <= m_reg && 7'(s_reg) >= row_start)
            begin
                i_work = lpc_lvl_t'(j);
                t_work = row_start;
            end
        end
        s_work = 6'(7'(s_reg) - t_work);

        if (m_reg < 4'd3)
        begin
            slots_next.slot0 = 6'd0;
            slots_next.slot1 = 6'd1;
            slots_next.slot2 = 6'd2;
            slots_next.pat   = 5'(v_reg);
        end
        else if (first_reg)
        begin
            slots_next.slot0 = 6'(m_reg);
            slots_next.slot1 = 6'(m_reg);
            slots_next.slot2 = 6'(m_reg);
            slots_next.pat   = 5'(FirstLvlPat);
        end
        else
        begin
            slots_next.slot0 = 6'(i_work);
            slots_next.slot1 = s_work + 6'(i_work);
            slots_next.slot2 = 6'(m_reg);
            slots_next.pat   = (s_work == '0) ? 5'(DiagBase) + 5'(mode)
                                              : 5'(PairBase) + 5'(mode);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg     <= m_next;
            v_reg     <= residue;
            first_reg <= first_next;
            rm1_reg   <= rm1_next;
            s_reg     <= s_next;
            slots_reg <= slots_next;
        end
    end

    assign out_valid = vb_reg;
    assign slots     = slots_reg;

endmodule

@@ rtl/core/lpc_color_map.sv @@
// Pattern lookup and intensity mapping into the output register.
module lpc_color_map (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  lpc_pkg::lpc_slots_t              slots,
    output logic                             out_valid,
    output logic [lpc_pkg::ColorWidth-1:0]   red,
    output logic [lpc_pkg::ColorWidth-1:0]   green,
    output logic [lpc_pkg::ColorWidth-1:0]   blue
);
    import lpc_pkg::*;

    lpc_pat_t            pat;
    logic [5:0]          sel;
    lpc_slot_t           pick [3];
    logic [ColorWidth-1:0] col_next [3];
    logic [ColorWidth-1:0] col_reg  [3];
    logic                valid_reg;

    function automatic lpc_slot_t slot_pick(input lpc_slots_t s, input logic [1:0] idx);
        lpc_slot_t p;
        case (idx)
            2'd0:    p = s.slot0;
            2'd1:    p = s.slot1;
            default: p = s.slot2;
        endcase
        return p;
    endfunction

    always_comb
    begin
        pat = (slots.pat >= 5'(NumPatterns)) ? 5'(NumPatterns - 1) : slots.pat;
        sel = lpc_pattern(pat);
        for (int c = 0; c < 3; c++)
        begin
            pick[c] = slot_pick(slots, sel[5-2*c -: 2]);
            if (pick[c] >= 6'(NumLevels))
                col_next[c] = lpc_level_value(4'(NumLevels - 1));
            else
                col_next[c] = lpc_level_value(pick[c][3:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_reg[0] <= col_next[0];
            col_reg[1] <= col_next[1];
            col_reg[2] <= col_next[2];
        end
    end

    assign out_valid = valid_reg;
    assign red       = col_reg[0];
    assign green     = col_reg[1];
    assign blue      = col_reg[2];

endmodule

@@ rtl/core/label_to_pseudo_color.sv @@
// Top level of the label to pseudo-color pipeline.
// Maps each segment label to one of 729 distinct RGB colors (colors repeat
// every 729 labels); each channel is one of nine intensities. The block is
// a six-stage pipeline and takes one word per cycle unless stalled. Stages:
// chunk folding mod 729, reciprocal multiply for the quotient, remainder,
// level search and split by six, triangular pair walk, and pattern/intensity
// lookup into the output register. When out_stall holds a waiting word the
// whole pipeline freezes and in_stall is raised in the same cycle; nothing is
// dropped or repeated. Bubbles are not squeezed out during a stall.
module label_to_pseudo_color (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [lpc_pkg::LabelWidth-1:0]   label,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [lpc_pkg::ColorWidth-1:0]   red,
    output logic [lpc_pkg::ColorWidth-1:0]   green,
    output logic [lpc_pkg::ColorWidth-1:0]   blue
);
    import lpc_pkg::*;

    logic       en;
    logic       res_valid;
    lpc_res_t   residue;
    logic       slots_valid;
    lpc_slots_t slots;

    // global advance: hold everything while the output word is not taken
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    lpc_mod_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .label     (label),
        .out_valid (res_valid),
        .residue   (residue)
    );

    lpc_level_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (res_valid),
        .residue   (residue),
        .out_valid (slots_valid),
        .slots     (slots)
    );

    lpc_color_map u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (slots_valid),
        .slots     (slots),
        .out_valid (out_valid),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

endmodule
